/* design/ultra_slow_multiwave_lfo_macros.svh */
// Assertion helpers for the LFO checker
`ifndef ULTRA_SLOW_MULTIWAVE_LFO_MACROS_SVH
`define ULTRA_SLOW_MULTIWAVE_LFO_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define USLFO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define USLFO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/uslfo_pkg.sv */
`default_nettype none

package uslfo_pkg;

  localparam int unsigned SINE_TABLE_BITS = 10;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DURATION_KNOB = 3'd0,
    REG_FM_DEPTH      = 3'd1,
    REG_PULSE_WIDTH   = 3'd2,
    REG_OFFSET_MODE   = 3'd3,
    REG_INVERT_MODE   = 3'd4,
    REG_SAMPLE_RATE   = 3'd5
  } reg_idx_e;

  localparam int unsigned KW   = 67;   // year seconds (Q8) times base multiplier
  localparam int unsigned DSW  = 33;   // duration times sample rate
  localparam int unsigned DVW  = KW + DSW;

  localparam logic [2:0]  BASE_LAST   = 3'd6;
  localparam logic [63:0] HALF_CYCLE  = 64'h8000_0000_0000_0000;
  localparam logic [DVW-1:0] TINY_DIV = DVW'(131072);

  localparam logic [14:0] DUR_MIN = 15'd256;
  localparam logic [14:0] DUR_MAX = 15'd25600;
  localparam logic [15:0] PW_MIN  = 16'd655;
  localparam logic [15:0] PW_MAX  = 16'd64880;
  localparam logic signed [12:0] AMP      = 13'sd1280;
  localparam logic signed [12:0] FULL_AMP = 13'sd2560;

  // Year length in Q8 seconds scaled by the multiplier of each time base
  function automatic logic [KW-1:0] base_const(input logic [2:0] base);
    logic [KW-1:0] k;
    case (base)
      3'd0:    k = 67'd8078573050;
      3'd1:    k = 67'd807857305000;
      3'd2:    k = 67'd8078573050000;
      3'd3:    k = 67'd8078573050000000;
      3'd4:    k = 67'd807857305000000000;
      3'd5:    k = 67'd111258108044600000000;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* design/ultra_slow_multiwave_lfo.sv */
`default_nettype none

// Ultra-slow LFO: sine, triangle, saw and square outputs in signed Q4.8 volts.
// One transaction in gives one transaction out. From acceptance to a ready
// result an item goes through a setup state, the bit-serial multiply that
// builds the period divisor, a check state, the restoring division of 2^80
// by that divisor, a state to advance the phase, the shared 18x18 multiplier
// steps that evaluate the sine polynomial and an output state. Once a result
// is loaded into the output register, the next item can be taken in the
// following cycle.
// On the heat-death time base or with a zero sample rate the multiply and
// division are skipped; with a divisor too small to divide only the division
// is skipped.
// Input is taken only between items; a finished result waits in the output
// register while the next item is being worked.
module ultra_slow_multiwave_lfo #(
  parameter int unsigned SineTableBits = uslfo_pkg::SINE_TABLE_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [uslfo_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [uslfo_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [12:0]                  fm_cv_i,
  input  wire logic                                fm_connected_i,
  input  wire logic signed [12:0]                  reset_cv_i,
  input  wire logic                                reset_connected_i,
  input  wire logic                                base_button_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [12:0]                       sine_out_o,
  output logic signed [12:0]                       triangle_out_o,
  output logic signed [12:0]                       saw_out_o,
  output logic signed [12:0]                       square_out_o,
  output logic [2:0]                               base_select_o,
  output logic [15:0]                              phase_view_o,
  output logic [14:0]                              duration_view_o
);

  localparam int unsigned QB = SineTableBits - 2;
  localparam int unsigned DVW = uslfo_pkg::DVW;
  localparam logic [6:0] DIV_TOP = 7'd80;
  localparam logic [6:0] MUL_TOP = 7'(uslfo_pkg::DSW - 1);

  // Polynomial sequencer steps
  localparam logic [2:0] SN_SQ = 3'd0;
  localparam logic [2:0] SN_T1 = 3'd1;
  localparam logic [2:0] SN_T2 = 3'd2;
  localparam logic [2:0] SN_T3 = 3'd3;
  localparam logic [2:0] SN_T4 = 3'd4;
  localparam logic [2:0] SN_Y  = 3'd5;
  localparam logic [2:0] SN_V  = 3'd6;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PREP  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_CHK   = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_APPLY = 8'b0010_0000,
    S_SIN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q;

  logic [14:0]        dur_knob_q;
  logic signed [9:0]  fm_depth_q;
  logic [15:0]        pulse_width_q;
  logic               offset_q;
  logic               invert_q;
  logic [17:0]        sample_rate_q;

  logic [63:0]        phase_q;
  logic [2:0]         base_q;
  logic               btn_armed_q;
  logic               rst_armed_q;
  logic signed [12:0] rst_cv_q;
  logic               rst_on_q;
  logic [14:0]        dur_q;
  logic [uslfo_pkg::DSW-1:0] ds_q;
  logic [DVW-1:0]     dv_q;
  logic [DVW-1:0]     rem_q;
  logic [63:0]        quo_q;
  logic [63:0]        inc_q;
  logic [6:0]         cnt_q;
  logic [2:0]         step_q;
  logic [17:0]        x2_q;
  logic [17:0]        t_q;
  logic [10:0]        v_q;

  // Accept-time duration and button edge
  logic               in_acc;
  logic               out_load;
  logic signed [22:0] fm_prod;
  logic signed [14:0] fm_adj;
  logic signed [17:0] dur_raw;
  logic [14:0]        dur_clamp;
  logic               btn_fire;
  logic [2:0]         base_nx;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_o || !out_stall_i);

  always_comb begin
    fm_prod = 23'(fm_cv_i) * 23'(fm_depth_q);
    fm_adj  = 15'(fm_prod >>> 8);
    dur_raw = $signed({3'b000, dur_knob_q}) + (fm_connected_i ? 18'(fm_adj) : 18'sd0);
    if (dur_raw < $signed({3'b000, uslfo_pkg::DUR_MIN})) begin
      dur_clamp = uslfo_pkg::DUR_MIN;
    end else if (dur_raw > $signed({3'b000, uslfo_pkg::DUR_MAX})) begin
      dur_clamp = uslfo_pkg::DUR_MAX;
    end else begin
      dur_clamp = dur_raw[14:0];
    end
    btn_fire = btn_armed_q && base_button_i;
    if (!btn_fire) begin
      base_nx = base_q;
    end else if (base_q == uslfo_pkg::BASE_LAST) begin
      base_nx = 3'd0;
    end else begin
      base_nx = base_q + 3'd1;
    end
  end

  // Divisor build and division step
  logic [uslfo_pkg::KW-1:0] kmul;
  logic [DVW:0]             rem_sh;
  logic                     div_ge;
  logic [63:0]              quo_nx;

  always_comb begin
    kmul   = uslfo_pkg::base_const(base_q);
    rem_sh = {rem_q, (cnt_q == DIV_TOP)};
    div_ge = rem_sh >= {1'b0, dv_q};
    quo_nx = {quo_q[62:0], div_ge};
  end

  // Sine table entry address from the phase
  logic [SineTableBits-1:0] sin_idx;
  logic [SineTableBits-1:0] sin_ent;
  logic [1:0]               quad;
  logic [16:0]              xa;
  logic [16:0]              x;

  always_comb begin
    sin_idx = phase_q[63 -: SineTableBits];
    sin_ent = sin_idx + (offset_q ? (SineTableBits'(1) << QB) : '0);
    quad    = sin_ent[SineTableBits-1 -: 2];
    xa      = 17'(sin_ent[QB-1:0]) << (16 - QB);
    x       = quad[0] ? 17'(17'h10000 - xa) : xa;
  end

  // Shared multiplier of the sine polynomial
  logic [17:0] ma;
  logic [17:0] mb;
  logic [35:0] prod;
  logic [19:0] sub_c;
  logic [19:0] v_rnd;

  always_comb begin
    case (step_q)
      SN_SQ: begin
        ma = 18'(x);  mb = 18'(x);  sub_c = 20'd0;
      end
      SN_T1: begin
        ma = x2_q;    mb = 18'd11;  sub_c = 20'd307;
      end
      SN_T2: begin
        ma = x2_q;    mb = t_q;     sub_c = 20'd5223;
      end
      SN_T3: begin
        ma = x2_q;    mb = t_q;     sub_c = 20'd42334;
      end
      SN_T4: begin
        ma = x2_q;    mb = t_q;     sub_c = 20'd102944;
      end
      SN_Y: begin
        ma = 18'(x);  mb = t_q;     sub_c = 20'd0;
      end
      SN_V: begin
        ma = t_q;     mb = 18'd1280; sub_c = 20'd0;
      end
      default: begin
        ma = '0;      mb = '0;      sub_c = 20'd0;
      end
    endcase
    prod  = 36'(ma) * 36'(mb);
    v_rnd = 20'((prod + 36'd32768) >> 16);
  end

  // Waveform shaping from the updated phase
  logic [31:0]        p32;
  logic [15:0]        top16;
  logic [31:0]        tri_u;
  logic [31:0]        tri_d;
  logic signed [12:0] tri_p;
  logic signed [12:0] tri_w;
  logic signed [12:0] saw_r;
  logic signed [12:0] saw_b;
  logic signed [12:0] saw_w;
  logic signed [12:0] rom_v;
  logic signed [12:0] rom_s;
  logic signed [12:0] sin_w;
  logic [15:0]        pw_c;
  logic signed [12:0] sqr_w;

  always_comb begin
    p32   = phase_q[63:32];
    top16 = phase_q[63:48];
    if (offset_q) begin
      tri_u = invert_q ? p32 - 32'h8000_0000 : p32;
    end else begin
      tri_u = invert_q ? p32 - 32'h4000_0000 : p32 - 32'hC000_0000;
    end
    tri_d = tri_u[31] ? 32'(33'h1_0000_0000 - 33'(tri_u)) : tri_u;
    tri_p = 13'((35'(tri_d) * 35'd5) >> 22);
    tri_w = offset_q ? tri_p : tri_p - uslfo_pkg::AMP;

    saw_r = 13'((35'(p32) * 35'd5) >> 23);
    if (offset_q) begin
      saw_w = invert_q ? uslfo_pkg::FULL_AMP - saw_r : saw_r;
      saw_b = saw_r;
    end else begin
      saw_b = p32[31] ? saw_r - uslfo_pkg::FULL_AMP : saw_r;
      saw_w = invert_q ? -saw_b : saw_b;
    end

    rom_v = quad[1] ? -$signed({2'b00, v_q}) : $signed({2'b00, v_q});
    rom_s = invert_q ? -rom_v : rom_v;
    sin_w = offset_q ? uslfo_pkg::AMP - rom_s : rom_s;

    if (pulse_width_q < uslfo_pkg::PW_MIN) begin
      pw_c = uslfo_pkg::PW_MIN;
    end else if (pulse_width_q > uslfo_pkg::PW_MAX) begin
      pw_c = uslfo_pkg::PW_MAX;
    end else begin
      pw_c = pulse_width_q;
    end
    sqr_w = ((top16 < pw_c) != invert_q) ? uslfo_pkg::AMP : -uslfo_pkg::AMP;
    if (offset_q) begin
      sqr_w = sqr_w + uslfo_pkg::AMP;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_knob_q    <= 15'd256;
      fm_depth_q    <= '0;
      pulse_width_q <= 16'd32768;
      offset_q      <= 1'b0;
      invert_q      <= 1'b0;
      sample_rate_q <= 18'd44100;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        uslfo_pkg::REG_DURATION_KNOB: dur_knob_q    <= cfg_data_i[14:0];
        uslfo_pkg::REG_FM_DEPTH:      fm_depth_q    <= cfg_data_i[9:0];
        uslfo_pkg::REG_PULSE_WIDTH:   pulse_width_q <= cfg_data_i[15:0];
        uslfo_pkg::REG_OFFSET_MODE:   offset_q      <= cfg_data_i[0];
        uslfo_pkg::REG_INVERT_MODE:   invert_q      <= cfg_data_i[0];
        uslfo_pkg::REG_SAMPLE_RATE:   sample_rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state and phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      base_q      <= '0;
      btn_armed_q <= 1'b0;
      rst_armed_q <= 1'b0;
      out_valid_o <= 1'b0;
      cnt_q       <= '0;
      step_q      <= '0;
    end else begin
      // raise on a new result, drop a taken one
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            base_q <= base_nx;
            if (btn_fire) begin
              btn_armed_q <= 1'b0;
              phase_q     <= '0;
            end else if (!base_button_i) begin
              btn_armed_q <= 1'b1;
            end
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          cnt_q <= MUL_TOP;
          if (base_q >= uslfo_pkg::BASE_LAST || sample_rate_q == '0) begin
            state_q <= S_APPLY;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt_q == '0) begin
            state_q <= S_CHK;
          end else begin
            cnt_q <= cnt_q - 7'd1;
          end
        end
        S_CHK: begin
          cnt_q   <= DIV_TOP;
          state_q <= (dv_q <= uslfo_pkg::TINY_DIV) ? S_APPLY : S_DIV;
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            state_q <= S_APPLY;
          end else begin
            cnt_q <= cnt_q - 7'd1;
          end
        end
        S_APPLY: begin
          // advance, unless a reset edge clears the phase
          if (rst_on_q && rst_armed_q && rst_cv_q >= 13'sd256) begin
            rst_armed_q <= 1'b0;
            phase_q     <= '0;
          end else begin
            phase_q <= phase_q + inc_q;
            if (rst_on_q && !rst_armed_q && rst_cv_q <= 13'sd0) begin
              rst_armed_q <= 1'b1;
            end
          end
          step_q  <= SN_SQ;
          state_q <= S_SIN;
        end
        S_SIN: begin
          if (step_q == SN_V) begin
            state_q <= S_OUT;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          dur_q    <= dur_clamp;
          rst_cv_q <= reset_cv_i;
          rst_on_q <= reset_connected_i;
        end
      end
      S_PREP: begin
        ds_q <= uslfo_pkg::DSW'(dur_q) * uslfo_pkg::DSW'(sample_rate_q);
        dv_q <= '0;
        if (base_q >= uslfo_pkg::BASE_LAST) begin
          inc_q <= '0;
        end else begin
          inc_q <= uslfo_pkg::HALF_CYCLE;
        end
      end
      S_MUL: begin
        dv_q <= {dv_q[DVW-2:0], 1'b0} + (ds_q[cnt_q[5:0]] ? DVW'(kmul) : '0);
      end
      S_CHK: begin
        rem_q <= '0;
        quo_q <= '0;
        inc_q <= uslfo_pkg::HALF_CYCLE;
      end
      S_DIV: begin
        rem_q <= div_ge ? DVW'(rem_sh - {1'b0, dv_q}) : rem_sh[DVW-1:0];
        quo_q <= quo_nx;
        if (cnt_q == '0) begin
          inc_q <= (quo_nx > uslfo_pkg::HALF_CYCLE) ? uslfo_pkg::HALF_CYCLE : quo_nx;
        end
      end
      S_SIN: begin
        case (step_q)
          SN_SQ: x2_q <= prod[33:16];
          SN_T1, SN_T2, SN_T3, SN_T4: t_q <= 18'(sub_c - prod[35:16]);
          SN_Y:  t_q  <= prod[33:16];
          SN_V:  v_q  <= (v_rnd > 20'd1280) ? 11'd1280 : v_rnd[10:0];
          default: ;
        endcase
      end
      S_OUT: begin
        if (!out_valid_o || !out_stall_i) begin
          sine_out_o      <= sin_w;
          triangle_out_o  <= tri_w;
          saw_out_o       <= saw_w;
          square_out_o    <= sqr_w;
          base_select_o   <= base_q;
          phase_view_o    <= top16;
          duration_view_o <= dur_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* design/uslfo_checker.sv */
`default_nettype none

`include "ultra_slow_multiwave_lfo_macros.svh"

module uslfo_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  base_select_o,
  input wire logic [14:0] duration_view_o
);

  // hold a stalled result
  `USLFO_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // one transaction at a time: busy right after taking one
  `USLFO_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // time base stays in its seven values
  `USLFO_ASSERT_IMP(a_base_range, out_valid_o, base_select_o <= uslfo_pkg::BASE_LAST)

  // duration is clamped to its legal span
  `USLFO_ASSERT_IMP(a_dur_range, out_valid_o, duration_view_o >= uslfo_pkg::DUR_MIN && duration_view_o <= uslfo_pkg::DUR_MAX)

endmodule

bind ultra_slow_multiwave_lfo uslfo_checker u_uslfo_checker (.*);

`default_nettype wire

/* tb/lfo_tick_checker.sv */
`timescale 1ns / 100ps

module lfo_tick_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [uslfo_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [uslfo_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic signed [12:0]                   fm_cv_i,
  input  logic                                 fm_connected_i,
  input  logic signed [12:0]                   reset_cv_i,
  input  logic                                 reset_connected_i,
  input  logic                                 base_button_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [12:0]                   sine_out_i,
  input  logic signed [12:0]                   triangle_out_i,
  input  logic signed [12:0]                   saw_out_i,
  input  logic signed [12:0]                   square_out_i,
  input  logic [2:0]                           base_select_i,
  input  logic [15:0]                          phase_view_i,
  input  logic [14:0]                          duration_view_i,
  output int                                   err_count_o,
  output int                                   pending_o,
  output int                                   results_seen_o
);

  localparam int unsigned TABLE_SIZE = 1 << uslfo_pkg::SINE_TABLE_BITS;
  localparam longint unsigned YEAR_Q8 = 64'd8078573050;
  localparam logic [63:0] HALF_STEP = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic signed [12:0] sine;
    logic signed [12:0] triangle;
    logic signed [12:0] saw;
    logic signed [12:0] sqr;
    logic [2:0]         base;
    logic [15:0]        phase;
    logic [14:0]        dur;
  } lfo_tick_t;

  longint unsigned base_scale [6] = '{64'd1, 64'd100, 64'd1000, 64'd1000000,
                                      64'd100000000, 64'd13772000000};

  // Shadow registers
  int unsigned knob_q;
  int          depth_q;
  int unsigned duty_q;
  bit          unipolar_q;
  bit          inverted_q;
  int unsigned rate_q;

  // Shadow state
  logic [63:0] phase_q;
  logic [2:0]  base_q;
  bit          button_armed_q;
  bit          reset_armed_q;

  int sine_table [TABLE_SIZE];
  lfo_tick_t expected_ticks [$];

  function automatic int quarter_wave(longint unsigned x);
    longint unsigned x2, t, y, v;
    x2 = (x * x) >> 16;
    t = 64'd307 - ((x2 * 64'd11) >> 16);
    t = 64'd5223 - ((x2 * t) >> 16);
    t = 64'd42334 - ((x2 * t) >> 16);
    t = 64'd102944 - ((x2 * t) >> 16);
    y = (x * t) >> 16;
    v = (y * 64'd1280 + 64'd32768) >> 16;
    if (v > 64'd1280) v = 64'd1280;
    return int'(v);
  endfunction

  initial begin
    int unsigned qbits, quad;
    longint unsigned x;
    int v;
    qbits = uslfo_pkg::SINE_TABLE_BITS - 2;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      quad = (i >> qbits) & 3;
      x = longint'(i & ((1 << qbits) - 1)) << (16 - qbits);
      if (quad[0]) x = 64'd65536 - x;
      v = quarter_wave(x);
      sine_table[i] = (quad >= 2) ? -v : v;
    end
  end

  function automatic logic [63:0] phase_increment(int unsigned dur, int unsigned rate,
                                                  int unsigned base);
    logic [127:0] divisor;
    logic [127:0] quo;
    if (base >= 6) return '0;
    if (rate == 0) return HALF_STEP;
    divisor = 128'(YEAR_Q8) * 128'(base_scale[base]) * 128'(dur) * 128'(rate);
    if (divisor <= 128'd131072) return HALF_STEP;
    quo = (128'd1 << 80) / divisor;
    return (quo[63:0] > HALF_STEP) ? HALF_STEP : quo[63:0];
  endfunction

  function automatic int tri_fold(logic [31:0] u);
    longint unsigned d;
    d = (u < 32'h8000_0000) ? longint'(u) : (64'h1_0000_0000 - longint'(u));
    return int'((d * 64'd5120) >> 32);
  endfunction

  // Advance the shadow state by one tick and form the expected outputs
  function automatic lfo_tick_t advance_tick(logic signed [12:0] fm, bit fm_on,
                                             logic signed [12:0] rst_cv, bit rst_on,
                                             bit button);
    lfo_tick_t r;
    longint dur;
    logic [31:0] p32;
    logic [15:0] top16;
    int unsigned idx, pw;
    int s, sine, triangle, saw, sqr;

    if (button_armed_q) begin
      if (button) begin
        button_armed_q = 0;
        base_q = (base_q == 3'd6) ? 3'd0 : base_q + 3'd1;
        phase_q = '0;
      end
    end else if (!button) begin
      button_armed_q = 1;
    end

    dur = longint'(knob_q);
    if (fm_on) dur += (longint'(fm) * longint'(depth_q)) >>> 8;
    if (dur < 256) dur = 256;
    if (dur > 25600) dur = 25600;

    phase_q += phase_increment(int'(dur), rate_q, base_q);

    if (rst_on) begin
      if (reset_armed_q) begin
        if (rst_cv >= 256) begin
          reset_armed_q = 0;
          phase_q = '0;
        end
      end else if (rst_cv <= 0) begin
        reset_armed_q = 1;
      end
    end

    p32 = phase_q[63:32];
    top16 = phase_q[63:48];
    s = inverted_q ? -1 : 1;
    idx = phase_q[63:64-uslfo_pkg::SINE_TABLE_BITS];

    if (unipolar_q) sine = 1280 - s * sine_table[(idx + TABLE_SIZE / 4) % TABLE_SIZE];
    else            sine = s * sine_table[idx];

    if (unipolar_q) triangle = tri_fold(inverted_q ? p32 - 32'h8000_0000 : p32);
    else triangle = -1280 + tri_fold(inverted_q ? p32 - 32'h4000_0000 : p32 - 32'hC000_0000);

    saw = int'((longint'(p32) * 64'd2560) >> 32);
    if (unipolar_q) begin
      if (inverted_q) saw = 2560 - saw;
    end else begin
      if (p32 >= 32'h8000_0000) saw -= 2560;
      saw *= s;
    end

    pw = duty_q;
    if (pw < 655) pw = 655;
    if (pw > 64880) pw = 64880;
    sqr = ((top16 < pw) != inverted_q) ? 1280 : -1280;
    if (unipolar_q) sqr += 1280;

    r.sine     = 13'(sine);
    r.triangle = 13'(triangle);
    r.saw      = 13'(saw);
    r.sqr      = 13'(sqr);
    r.base     = base_q;
    r.phase    = top16;
    r.dur      = 15'(dur);
    return r;
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count_o++;
    end
  endtask

  assign pending_o = expected_ticks.size();

  always @(posedge clk_i or negedge rst_ni) begin
    lfo_tick_t want;
    if (!rst_ni) begin
      knob_q = 256; depth_q = 0; duty_q = 32768;
      unipolar_q = 0; inverted_q = 0; rate_q = 44100;
      phase_q = '0; base_q = '0; button_armed_q = 0; reset_armed_q = 0;
      expected_ticks.delete();
      err_count_o = 0;
      results_seen_o = 0;
    end else begin
      // Check the result transaction against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        results_seen_o++;
        if (expected_ticks.size() == 0) begin
          $display("%0t: result transaction with no prediction pending", $time);
          err_count_o++;
        end else begin
          want = expected_ticks.pop_front();
          compare_field("sine_out", want.sine, sine_out_i);
          compare_field("triangle_out", want.triangle, triangle_out_i);
          compare_field("saw_out", want.saw, saw_out_i);
          compare_field("square_out", want.sqr, square_out_i);
          compare_field("base_select", want.base, base_select_i);
          compare_field("phase_view", want.phase, phase_view_i);
          compare_field("duration_view", want.dur, duration_view_i);
        end
      end
      // Predict for each accepted input transaction
      if (in_valid_i && !in_stall_i)
        expected_ticks.push_back(advance_tick(fm_cv_i, fm_connected_i, reset_cv_i,
                                              reset_connected_i, base_button_i));
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          uslfo_pkg::REG_DURATION_KNOB: knob_q = cfg_data_i[14:0];
          uslfo_pkg::REG_FM_DEPTH:      depth_q = int'($signed(cfg_data_i[9:0]));
          uslfo_pkg::REG_PULSE_WIDTH:   duty_q = cfg_data_i[15:0];
          uslfo_pkg::REG_OFFSET_MODE:   unipolar_q = cfg_data_i[0];
          uslfo_pkg::REG_INVERT_MODE:   inverted_q = cfg_data_i[0];
          uslfo_pkg::REG_SAMPLE_RATE:   rate_q = cfg_data_i[17:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int NUM_SETTINGS = 10;
  localparam int ITEMS_PER_SETTING = 193;
  localparam int CDW = uslfo_pkg::CFG_DATA_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [uslfo_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [uslfo_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [12:0] fm_cv = '0;
  logic fm_connected = 1'b0;
  logic signed [12:0] reset_cv = '0;
  logic reset_connected = 1'b0;
  logic base_button = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [12:0] sine_out, triangle_out, saw_out, square_out;
  logic [2:0] base_select;
  logic [15:0] phase_view;
  logic [14:0] duration_view;

  int err_count, pending, results_seen;
  int items_sent = 0;
  int idle_cycles = 0;
  bit hold_req = 0;
  bit hold_taken = 0;
  bit rst_high = 0;

  ultra_slow_multiwave_lfo u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .fm_cv_i(fm_cv), .fm_connected_i(fm_connected),
    .reset_cv_i(reset_cv), .reset_connected_i(reset_connected),
    .base_button_i(base_button),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .sine_out_o(sine_out), .triangle_out_o(triangle_out),
    .saw_out_o(saw_out), .square_out_o(square_out),
    .base_select_o(base_select), .phase_view_o(phase_view),
    .duration_view_o(duration_view)
  );

  lfo_tick_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .fm_cv_i(fm_cv), .fm_connected_i(fm_connected),
    .reset_cv_i(reset_cv), .reset_connected_i(reset_connected),
    .base_button_i(base_button),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .sine_out_i(sine_out), .triangle_out_i(triangle_out),
    .saw_out_i(saw_out), .square_out_i(square_out),
    .base_select_i(base_select), .phase_view_i(phase_view),
    .duration_view_i(duration_view),
    .err_count_o(err_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("[ultra_slow_multiwave_lfo] ERROR");
        $finish;
      end
    end
  end

  // Output stall: random modes, plus one long hold-off on request
  initial begin
    int mode, span;
    @(posedge rst_n);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1;
        out_stall <= 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      for (int c = 0; c < span; c++) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((c / 7) % 2 == 1);
        endcase
        @(posedge clk);
      end
    end
  end

  // Drive one input transaction and hold it until accepted
  task automatic send_tick(logic signed [12:0] fm, bit fm_on, logic signed [12:0] rcv,
                           bit r_on, bit btn);
    in_valid <= 1'b1;
    fm_cv <= fm;
    fm_connected <= fm_on;
    reset_cv <= rcv;
    reset_connected <= r_on;
    base_button <= btn;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drain the block, then write every register
  task automatic load_settings(int unsigned knob, int depth, int unsigned duty,
                               bit uni, bit inv, int unsigned rate);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= uslfo_pkg::REG_DURATION_KNOB; cfg_data <= CDW'(knob);            @(posedge clk);
    cfg_idx <= uslfo_pkg::REG_FM_DEPTH;      cfg_data <= CDW'(depth & 10'h3FF); @(posedge clk);
    cfg_idx <= uslfo_pkg::REG_PULSE_WIDTH;   cfg_data <= CDW'(duty);            @(posedge clk);
    cfg_idx <= uslfo_pkg::REG_OFFSET_MODE;   cfg_data <= CDW'(uni);             @(posedge clk);
    cfg_idx <= uslfo_pkg::REG_INVERT_MODE;   cfg_data <= CDW'(inv);             @(posedge clk);
    cfg_idx <= uslfo_pkg::REG_SAMPLE_RATE;   cfg_data <= CDW'(rate);            @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int burst, gap;
    bit btn;
    logic signed [12:0] fm, rcv;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, button walking every time base and wrapping,
    // reset edges, FM patched and unpatched
    for (int i = 0; i < 18; i++) begin
      fm = (i % 4 == 0) ? 13'sh1000 : (i % 4 == 1) ? 13'sh0FFF :
           (i % 4 == 2) ? -13'sd2560 : 13'sd2560;
      rcv = (i % 3 == 0) ? 13'sh1000 : (i % 3 == 1) ? 13'sd4095 : 13'sd256;
      send_tick(fm, i[0], rcv, (i % 5 != 4), i[0]);
    end

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      case (ph)
        0: load_settings(256, -256, 655, 0, 0, 8000);
        1: load_settings(25600, 256, 64880, 1, 1, 192000);
        2: load_settings(32767, -512, 0, 1, 0, 0);
        3: load_settings(0, 511, 65535, 0, 1, 1);
        4: load_settings(1000, 128, 20000, 1, 1, 0);
        default: load_settings($urandom_range(256, 25600), $urandom_range(0, 512) - 256,
                               $urandom_range(655, 64880), $urandom_range(0, 1),
                               $urandom_range(0, 1),
                               ($urandom_range(0, 2) == 0) ? $urandom_range(0, 64)
                                                           : $urandom_range(0, 262143));
      endcase
      if (ph == 6) hold_req = 1;
      btn = base_button;
      burst = $urandom_range(1, 40);
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        if ($urandom_range(0, 5) == 0) btn = ~btn;
        if ($urandom_range(0, 3) == 0) rst_high = ~rst_high;
        fm = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, 5120) - 2560);
        if ($urandom_range(0, 9) == 0) rcv = 13'($urandom);
        else rcv = rst_high ? 13'($urandom_range(256, 2560)) : 13'(-$urandom_range(0, 2560));
        send_tick(fm, $urandom_range(0, 3) != 0, rcv, $urandom_range(0, 7) != 0, btn);
        // Insert a gap at the end of each burst
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 40);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    // Drain and settle
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d input transactions and %0d results over %0d register settings,",
             items_sent, results_seen, NUM_SETTINGS + 1);
    $display("including extreme and out-of-range settings and a long output hold-off.");
    if (err_count == 0 && pending == 0) begin
      $display("[ultra_slow_multiwave_lfo] OK");
    end else begin
      $display("[ultra_slow_multiwave_lfo] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/uslfo_pkg.sv
design/ultra_slow_multiwave_lfo.sv
design/uslfo_checker.sv
tb/lfo_tick_checker.sv
tb/tb_top.sv
